// ===== rtl/gls_pkg.sv =====
// ============================================================================
// gls_pkg
// Shared types and constants for the galloping lower-bound search unit.
// ============================================================================
package gls_pkg;

    localparam int DEPTH_DEFAULT      = 4096;
    localparam int PEEK_LANES_DEFAULT = 16;
    localparam int QUEUE_DEPTH        = 4;
    localparam int MAX_PENDING        = QUEUE_DEPTH + 2;

    localparam int INDEX_W  = 12;
    localparam int END_W    = 13;
    localparam int KEY_W    = 32;
    localparam int RESULT_W = 13;
    localparam int KIND_W   = 2;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE  = 2'd0,
        KIND_SEARCH = 2'd1,
        KIND_DIRECT = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_LAST   = 3'd1,
        ST_SCAN   = 3'd2,
        ST_GALLOP = 3'd3,
        ST_NARROW = 3'd4,
        ST_BIN    = 3'd5,
        ST_RES    = 3'd6
    } state_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ===== rtl/galloping_lower_bound_search_unit.sv =====
// ============================================================================
// galloping_lower_bound_search_unit
// Store of sorted signed keys with a galloping lower-bound search engine.
// ============================================================================
// A write transaction (op low) stores one key and gives no result; a search
// transaction (op high) gives one result_index, the first position in the
// clamped range whose key is not below search_key, or the range end. Results
// leave in the order the searches arrived. A search on an empty range goes
// straight to the result register, and one whose last element is below the
// key exits early with the range end. Any other search is taken from the
// queue, reads the last element, peeks at the front min(range, PEEK_LANES)
// keys, makes its gallop probes, runs binary steps of a probe and a narrowing
// each, closes the binary phase, scans a tail of fewer than 2*PEEK_LANES
// keys, and loads the result register. The single read port of the key store
// delivers one key per cycle. A four-entry queue in front of the engine keeps
// taking transactions while a search runs or a result waits to be taken.
module galloping_lower_bound_search_unit #(
    parameter int DEPTH      = gls_pkg::DEPTH_DEFAULT,
    parameter int PEEK_LANES = gls_pkg::PEEK_LANES_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               op,
    input  logic [gls_pkg::INDEX_W-1:0]        write_index,
    input  logic signed [gls_pkg::KEY_W-1:0]   element_value,
    input  logic [gls_pkg::INDEX_W-1:0]        range_begin,
    input  logic [gls_pkg::END_W-1:0]          range_end,
    input  logic signed [gls_pkg::KEY_W-1:0]   search_key,
    output logic                               result_valid,
    input  logic                               result_ready,
    output logic [gls_pkg::RESULT_W-1:0]       result_index
);
    import gls_pkg::*;

    localparam int PW      = $clog2(DEPTH + 1);
    localparam int ENTRY_W = KIND_W + 2 * PW + KEY_W;

    q_status_t          q_status;
    logic               push;
    logic               pop;
    logic [ENTRY_W-1:0] push_entry;
    logic [ENTRY_W-1:0] pop_entry;

    gls_front #(
        .DEPTH   (DEPTH),
        .ENTRY_W (ENTRY_W)
    ) u_front (
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .write_index   (write_index),
        .element_value (element_value),
        .range_begin   (range_begin),
        .range_end     (range_end),
        .search_key    (search_key),
        .q_status      (q_status),
        .push          (push),
        .entry         (push_entry)
    );

    gls_queue #(
        .WIDTH  (ENTRY_W),
        .QDEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_entry),
        .pop       (pop),
        .pop_data  (pop_entry),
        .status    (q_status)
    );

    gls_engine #(
        .DEPTH      (DEPTH),
        .PEEK_LANES (PEEK_LANES),
        .ENTRY_W    (ENTRY_W)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_status     (q_status),
        .q_entry      (pop_entry),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_index (result_index)
    );

endmodule

// ===== rtl/gls_front.sv =====
// ============================================================================
// gls_front
// Accepts input transactions, clamps the range and classifies each item as a
// store write, a search, or a search whose answer is the range end.
// ============================================================================
module gls_front #(
    parameter int DEPTH   = gls_pkg::DEPTH_DEFAULT,
    parameter int ENTRY_W = 2
) (
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               op,
    input  logic [gls_pkg::INDEX_W-1:0]        write_index,
    input  logic signed [gls_pkg::KEY_W-1:0]   element_value,
    input  logic [gls_pkg::INDEX_W-1:0]        range_begin,
    input  logic [gls_pkg::END_W-1:0]          range_end,
    input  logic signed [gls_pkg::KEY_W-1:0]   search_key,
    input  gls_pkg::q_status_t                 q_status,
    output logic                               push,
    output logic [ENTRY_W-1:0]                 entry
);
    import gls_pkg::*;

    localparam int PW = $clog2(DEPTH + 1);
    localparam int CW = (PW > END_W) ? PW : END_W;

    logic [CW-1:0]  end_c;
    logic [CW-1:0]  end_cl;
    logic [CW-1:0]  beg_c;
    logic [CW-1:0]  idx_c;
    logic [CW-1:0]  depth_c;
    logic           is_write;
    kind_t          kind;
    logic [PW-1:0]  pos_a;
    logic [PW-1:0]  pos_b;
    logic [KEY_W-1:0] data;

    assign depth_c  = CW'(DEPTH);
    assign end_c    = CW'(range_end);
    assign end_cl   = (end_c > depth_c) ? depth_c : end_c;
    assign beg_c    = CW'(range_begin);
    assign idx_c    = CW'(write_index);
    assign is_write = (op == OP_WRITE);

    assign in_ready = !q_status.full;
    assign push     = in_valid && in_ready && (!is_write || (idx_c < depth_c));

    always_comb
    begin
        if (is_write)
        begin
            kind = KIND_WRITE;
        end
        else if (beg_c >= end_cl)
        begin
            kind = KIND_DIRECT;
        end
        else
        begin
            kind = KIND_SEARCH;
        end
    end

    assign pos_a = is_write ? PW'(idx_c) : PW'(beg_c);
    assign pos_b = PW'(end_cl);
    assign data  = is_write ? element_value : search_key;
    assign entry = {kind, pos_a, pos_b, data};

endmodule

// ===== rtl/gls_queue.sv =====
// ============================================================================
// gls_queue
// Short first-in first-out queue between the front end and the search engine.
// ============================================================================
module gls_queue #(
    parameter int WIDTH   = 8,
    parameter int QDEPTH  = gls_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic [WIDTH-1:0]   push_data,
    input  logic               pop,
    output logic [WIDTH-1:0]   pop_data,
    output gls_pkg::q_status_t status
);
    import gls_pkg::*;

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);

    logic [WIDTH-1:0] slot_reg [QDEPTH];
    logic [PTR_W-1:0] wptr_reg;
    logic [PTR_W-1:0] wptr_next;
    logic [PTR_W-1:0] rptr_reg;
    logic [PTR_W-1:0] rptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign status.full  = (count_reg == CNT_W'(QDEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_data     = slot_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/gls_engine.sv =====
// ============================================================================
// gls_engine
// Owns the key store and carries out writes and galloping searches, one
// store read per cycle, and holds the result transaction until it is taken.
// ============================================================================
module gls_engine #(
    parameter int DEPTH      = gls_pkg::DEPTH_DEFAULT,
    parameter int PEEK_LANES = gls_pkg::PEEK_LANES_DEFAULT,
    parameter int ENTRY_W    = 2
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  gls_pkg::q_status_t             q_status,
    input  logic [ENTRY_W-1:0]             q_entry,
    output logic                           pop,
    output logic                           result_valid,
    input  logic                           result_ready,
    output logic [gls_pkg::RESULT_W-1:0]   result_index
);
    import gls_pkg::*;

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = $clog2(DEPTH + 1);
    localparam int GW    = PW + 8;
    localparam int CNT_W = $clog2(PEEK_LANES + 1);

    logic signed [KEY_W-1:0] mem [DEPTH];
    logic signed [KEY_W-1:0] rd_data_reg;
    logic [AW-1:0]           rd_addr;
    logic                    mem_we;

    kind_t                   q_kind;
    logic [PW-1:0]           q_pos_a;
    logic [PW-1:0]           q_pos_b;
    logic signed [KEY_W-1:0] q_data;

    state_t                  state_reg, state_next;
    logic [PW-1:0]           beg_reg, beg_next;
    logic [PW-1:0]           end_reg, end_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic [PW-1:0]           lo_reg, lo_next;
    logic [PW-1:0]           hi_reg, hi_next;
    logic [PW-1:0]           mid_reg, mid_next;
    logic [PW-1:0]           peek_reg, peek_next;
    logic [GW-1:0]           jump_reg, jump_next;
    logic [CNT_W-1:0]        i_reg, i_next;
    logic [CNT_W-1:0]        n_reg, n_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    tail_reg, tail_next;
    logic [PW-1:0]           res_reg, res_next;
    logic                    out_valid_reg;
    logic [RESULT_W-1:0]     out_index_reg;
    logic                    res_load;

    logic                    below;
    logic [CNT_W-1:0]        cnt_sum;
    logic                    scan_last;
    logic [AW-1:0]           scan_next_addr;
    logic [PW-1:0]           found_pos;
    logic [GW-1:0]           peek_first;
    logic [GW-1:0]           jump_dbl;
    logic [GW-1:0]           peek_dbl;
    logic [GW-1:0]           tail_lo;
    logic [GW-1:0]           span;
    logic [PW-1:0]           mid;
    logic [GW-1:0]           end_g;
    logic                    go_narrow;
    logic                    go_scan;
    logic [GW-1:0]           nar_lo;
    logic [GW-1:0]           nar_hi;

    function automatic logic [CNT_W-1:0] scan_count(input logic [PW-1:0] lo,
                                                    input logic [PW-1:0] hi);
        logic [GW-1:0] d;
        d = GW'(hi) - GW'(lo);
        if (d >= GW'(PEEK_LANES))
        begin
            return CNT_W'(PEEK_LANES);
        end
        return CNT_W'(d);
    endfunction

    assign q_kind  = kind_t'(q_entry[ENTRY_W-1 -: KIND_W]);
    assign q_pos_a = q_entry[2*PW+KEY_W-1 -: PW];
    assign q_pos_b = q_entry[PW+KEY_W-1 -: PW];
    assign q_data  = q_entry[KEY_W-1:0];

    assign below          = (rd_data_reg < key_reg);
    assign cnt_sum        = cnt_reg + CNT_W'(below);
    assign scan_last      = ((i_reg + CNT_W'(1)) == n_reg);
    assign scan_next_addr = AW'(GW'(lo_reg) + GW'(i_reg) + GW'(1));
    assign found_pos      = PW'(GW'(lo_reg) + GW'(cnt_sum));
    assign peek_first     = GW'(beg_reg) + GW'(PEEK_LANES);
    assign jump_dbl       = jump_reg << 1;
    assign peek_dbl       = GW'(beg_reg) + jump_dbl;
    assign tail_lo        = GW'(lo_reg) + GW'(n_reg);
    assign span           = GW'(hi_reg) - GW'(lo_reg);
    assign mid            = PW'((GW'(lo_reg) + GW'(hi_reg)) >> 1);
    assign end_g          = GW'(end_reg);

    assign result_valid = out_valid_reg;
    assign result_index = out_index_reg;

    always_comb
    begin
        state_next = state_reg;
        beg_next   = beg_reg;
        end_next   = end_reg;
        key_next   = key_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        peek_next  = peek_reg;
        jump_next  = jump_reg;
        i_next     = i_reg;
        n_next     = n_reg;
        cnt_next   = cnt_reg;
        tail_next  = tail_reg;
        res_next   = res_reg;
        rd_addr    = AW'(peek_reg);
        pop        = 1'b0;
        mem_we     = 1'b0;
        res_load   = 1'b0;
        go_narrow  = 1'b0;
        go_scan    = 1'b0;
        nar_lo     = '0;
        nar_hi     = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop = 1'b1;
                    unique case (q_kind)
                        KIND_WRITE:
                        begin
                            mem_we = 1'b1;
                        end
                        KIND_SEARCH:
                        begin
                            beg_next   = q_pos_a;
                            end_next   = q_pos_b;
                            key_next   = q_data;
                            rd_addr    = AW'(q_pos_b - PW'(1));
                            state_next = ST_LAST;
                        end
                        KIND_DIRECT:
                        begin
                            res_next   = q_pos_b;
                            state_next = ST_RES;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_LAST:
            begin
                if (below)
                begin
                    res_next   = end_reg;
                    state_next = ST_RES;
                end
                else
                begin
                    lo_next   = beg_reg;
                    hi_next   = end_reg;
                    tail_next = 1'b0;
                    go_scan   = 1'b1;
                end
            end
            ST_SCAN:
            begin
                if (!scan_last)
                begin
                    i_next   = i_reg + CNT_W'(1);
                    cnt_next = cnt_sum;
                    rd_addr  = scan_next_addr;
                end
                else if (cnt_sum != n_reg)
                begin
                    res_next   = found_pos;
                    state_next = ST_RES;
                end
                else if (!tail_reg)
                begin
                    jump_next = GW'(PEEK_LANES);
                    if (peek_first >= end_g)
                    begin
                        go_narrow = 1'b1;
                        nar_lo    = GW'(PEEK_LANES >> 1) + GW'(beg_reg) + GW'(1);
                        nar_hi    = end_g;
                    end
                    else
                    begin
                        peek_next  = PW'(peek_first);
                        rd_addr    = AW'(peek_first);
                        state_next = ST_GALLOP;
                    end
                end
                else if (tail_lo < GW'(hi_reg))
                begin
                    lo_next = PW'(tail_lo);
                    go_scan = 1'b1;
                end
                else
                begin
                    res_next   = hi_reg;
                    state_next = ST_RES;
                end
            end
            ST_GALLOP:
            begin
                if (below)
                begin
                    jump_next = jump_dbl;
                    if (peek_dbl >= end_g)
                    begin
                        go_narrow = 1'b1;
                        nar_lo    = (jump_dbl >> 1) + GW'(beg_reg) + GW'(1);
                        nar_hi    = end_g;
                    end
                    else
                    begin
                        peek_next = PW'(peek_dbl);
                        rd_addr   = AW'(peek_dbl);
                    end
                end
                else
                begin
                    go_narrow = 1'b1;
                    nar_lo    = (jump_reg >> 1) + GW'(beg_reg) + GW'(1);
                    nar_hi    = GW'(peek_reg) + GW'(1);
                end
            end
            ST_NARROW:
            begin
                if (span >= GW'(2 * PEEK_LANES))
                begin
                    mid_next   = mid;
                    rd_addr    = AW'(mid);
                    state_next = ST_BIN;
                end
                else if (lo_reg < hi_reg)
                begin
                    tail_next = 1'b1;
                    go_scan   = 1'b1;
                end
                else
                begin
                    res_next   = hi_reg;
                    state_next = ST_RES;
                end
            end
            ST_BIN:
            begin
                if (below)
                begin
                    lo_next = mid_reg + PW'(1);
                end
                else
                begin
                    hi_next = mid_reg;
                end
                state_next = ST_NARROW;
            end
            ST_RES:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (go_narrow)
        begin
            if (nar_lo > nar_hi)
            begin
                res_next   = PW'(nar_hi);
                state_next = ST_RES;
            end
            else
            begin
                lo_next    = PW'(nar_lo);
                hi_next    = PW'(nar_hi);
                state_next = ST_NARROW;
            end
        end

        if (go_scan)
        begin
            i_next     = '0;
            cnt_next   = '0;
            n_next     = scan_count(lo_next, hi_next);
            rd_addr    = AW'(lo_next);
            state_next = ST_SCAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        beg_reg  <= beg_next;
        end_reg  <= end_next;
        key_reg  <= key_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        mid_reg  <= mid_next;
        peek_reg <= peek_next;
        jump_reg <= jump_next;
        i_reg    <= i_next;
        n_reg    <= n_next;
        cnt_reg  <= cnt_next;
        tail_reg <= tail_next;
        res_reg  <= res_next;
        if (res_load)
        begin
            out_index_reg <= RESULT_W'(res_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[AW'(q_pos_a)] <= q_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

endmodule

// ===== rtl/gls_checker.sv =====
// ============================================================================
// gls_checker
// Port-level checks on result transactions against the searches accepted.
// ============================================================================
module gls_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         op,
    input logic                         result_valid,
    input logic                         result_ready,
    input logic [gls_pkg::RESULT_W-1:0] result_index
);
    import gls_pkg::*;

    logic [7:0] pending_reg;
    logic       search_in;
    logic       result_out;

    assign search_in  = in_valid && in_ready && (op == OP_SEARCH);
    assign result_out = result_valid && result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (search_in && !result_out)
        begin
            pending_reg <= pending_reg + 8'd1;
        end
        else if (result_out && !search_in)
        begin
            pending_reg <= pending_reg - 8'd1;
        end
    end

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result transaction dropped before it was taken");

    a_index_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result_index))
        else $error("result_index changed while stalled");

    a_result_has_search: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> pending_reg != 8'd0)
        else $error("result transaction without an outstanding search");

    a_pending_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 8'(MAX_PENDING))
        else $error("more searches outstanding than the unit can hold");

endmodule

bind galloping_lower_bound_search_unit gls_checker u_checker (.*);

// ===== verif/gls_search_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// gls_search_checker
// Watches both channels of the search unit, predicts each search result from
// a private image of the key store, and compares every result transaction.
// ============================================================================
module gls_search_checker #(
    parameter int DEPTH = gls_pkg::DEPTH_DEFAULT,
    parameter int LANES = gls_pkg::PEEK_LANES_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic                                op,
    input  logic [gls_pkg::INDEX_W-1:0]         write_index,
    input  logic signed [gls_pkg::KEY_W-1:0]    element_value,
    input  logic [gls_pkg::INDEX_W-1:0]         range_begin,
    input  logic [gls_pkg::END_W-1:0]           range_end,
    input  logic signed [gls_pkg::KEY_W-1:0]    search_key,
    input  logic                                result_valid,
    input  logic                                result_ready,
    input  logic [gls_pkg::RESULT_W-1:0]        result_index,
    output int                                  mismatch_count,
    output int                                  results_pending
);
    import gls_pkg::*;

    logic signed [KEY_W-1:0] key_image [DEPTH];
    logic [RESULT_W-1:0]     expected_index [$];
    logic [RESULT_W-1:0]     oldest_index;

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic bit key_lower(input int unsigned pos, input logic signed [KEY_W-1:0] k);
        return key_image[pos] < k;
    endfunction

    // Scans up to LANES positions from lo; hit is lo plus the lanes below the key.
    function automatic bit lane_probe(input int unsigned lo, input int unsigned hi,
                                      input logic signed [KEY_W-1:0] k,
                                      output int unsigned hit);
        int unsigned lanes;
        int unsigned below;
        lanes = hi - lo;
        if (lanes > LANES)
            lanes = LANES;
        below = 0;
        for (int unsigned i = 0; i < lanes; i++)
            if (key_lower(lo + i, k))
                below++;
        hit = lo + below;
        return below != lanes;
    endfunction

    function automatic int unsigned refine(input int unsigned lo, input int unsigned hi,
                                           input logic signed [KEY_W-1:0] k);
        int unsigned mid;
        int unsigned hit;
        if (lo > hi)
            return hi;
        while (hi - lo >= 2 * LANES) begin
            mid = (lo + hi) >> 1;
            if (key_lower(mid, k))
                lo = mid + 1;
            else
                hi = mid;
        end
        while (lo < hi) begin
            if (lane_probe(lo, hi, k, hit))
                return hit;
            lo += (hi - lo >= LANES) ? LANES : (hi - lo);
        end
        return hi;
    endfunction

    function automatic int unsigned lower_bound_of(input int unsigned beg, input int unsigned stop,
                                                   input logic signed [KEY_W-1:0] k);
        int unsigned hit;
        int unsigned stride;
        int unsigned probe;
        if (key_lower(stop - 1, k))
            return stop;
        if (lane_probe(beg, stop, k, hit))
            return hit;
        stride = LANES;
        while (1'b1) begin
            probe = beg + stride;
            if (probe >= stop)
                return refine((stride >> 1) + beg + 1, stop, k);
            if (key_lower(probe, k))
                stride = stride << 1;
            else
                return refine((stride >> 1) + beg + 1, probe + 1, k);
        end
        return stop;
    endfunction

    function automatic logic [RESULT_W-1:0] predict_search(input logic [INDEX_W-1:0] beg,
                                                          input logic [END_W-1:0] rend,
                                                          input logic signed [KEY_W-1:0] k);
        int unsigned stop;
        stop = (rend > DEPTH) ? DEPTH : rend;
        if (beg >= stop)
            return RESULT_W'(stop);
        return RESULT_W'(lower_bound_of(beg, stop, k));
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            expected_index.delete();
            results_pending <= 0;
        end else begin
            if (in_valid && in_ready) begin
                if (op == OP_WRITE) begin
                    if (write_index < DEPTH)
                        key_image[write_index] = element_value;
                end else begin
                    expected_index.push_back(predict_search(range_begin, range_end, search_key));
                end
            end
            if (result_valid && result_ready) begin
                if (expected_index.size() == 0) begin
                    report_mismatch($sformatf("result transaction %0d with no search outstanding",
                                              result_index));
                end else begin
                    oldest_index = expected_index.pop_front();
                    if (result_index !== oldest_index)
                        report_mismatch($sformatf("result_index %0d, predicted %0d",
                                                  result_index, oldest_index));
                end
            end
            results_pending <= expected_index.size();
        end
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Stimulus for the galloping lower-bound search unit: key runs, mostly sorted,
// are loaded and searched under random idling on both channels.
// ============================================================================
module tb_top;
    import gls_pkg::*;

    localparam int DEPTH        = DEPTH_DEFAULT;
    localparam int ITEM_TARGET  = 1450;
    localparam int CALM_FROM    = 1250;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 200;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic                    op;
    logic [INDEX_W-1:0]      write_index;
    logic signed [KEY_W-1:0] element_value;
    logic [INDEX_W-1:0]      range_begin;
    logic [END_W-1:0]        range_end;
    logic signed [KEY_W-1:0] search_key;
    logic                    result_valid;
    logic                    result_ready;
    logic [RESULT_W-1:0]     result_index;
    int                      mismatch_count;
    int                      results_pending;

    logic signed [KEY_W-1:0] shadow_key [DEPTH];
    bit                      written [DEPTH];
    logic signed [KEY_W-1:0] seed_keys [16];
    int unsigned             items_sent;
    int unsigned             send_idle_pct;
    int unsigned             ready_idle_pct;
    int unsigned             cycle_count;
    bit                      calm;
    bit                      long_hold_request;

    galloping_lower_bound_search_unit dut (.*);

    gls_search_checker checker_i (.*);

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // The result side stalls in bursts, and once for a long stretch so that
    // the input queue fills up behind it.
    initial begin
        bit hold_done;
        hold_done    = 1'b0;
        result_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (long_hold_request && !hold_done) begin
                hold_done = 1'b1;
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                result_ready <= 1'b1;
            end else if (!calm && $urandom_range(0, 99) < ready_idle_pct) begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
                result_ready <= 1'b1;
            end else begin
                result_ready <= 1'b1;
            end
        end
    end

    task automatic push_item(input logic kind, input logic [INDEX_W-1:0] widx,
                             input logic signed [KEY_W-1:0] wval,
                             input logic [INDEX_W-1:0] beg, input logic [END_W-1:0] rend,
                             input logic signed [KEY_W-1:0] key);
        int unsigned gap;
        gap = 0;
        if (!calm && $urandom_range(0, 99) < send_idle_pct)
            gap = $urandom_range(1, 11);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        op            <= kind;
        write_index   <= widx;
        element_value <= wval;
        range_begin   <= beg;
        range_end     <= rend;
        search_key    <= key;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
    endtask

    task automatic push_write(input int unsigned idx, input logic signed [KEY_W-1:0] val);
        push_item(OP_WRITE, INDEX_W'(idx), val, INDEX_W'($urandom()), END_W'($urandom()),
                  $urandom());
        shadow_key[idx] = val;
        written[idx]    = 1'b1;
    endtask

    task automatic push_search(input int unsigned beg, input int unsigned rend,
                               input logic signed [KEY_W-1:0] key);
        push_item(OP_SEARCH, INDEX_W'($urandom()), $urandom(), INDEX_W'(beg), END_W'(rend),
                  key);
    endtask

    function automatic logic signed [KEY_W-1:0] choose_key(input int unsigned lo,
                                                           input int unsigned hi);
        longint      k;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        k    = shadow_key[$urandom_range(lo, hi - 1)];
        if (pick < 35)
            return KEY_W'(k);
        if (pick < 55) begin
            k = $urandom_range(0, 1) ? k + 1 : k - 1;
            if (k > KEY_MAX)
                k = KEY_MAX;
            if (k < KEY_MIN)
                k = KEY_MIN;
            return KEY_W'(k);
        end
        if (pick < 65)
            return $urandom_range(0, 1) ? KEY_MAX : KEY_MIN;
        return $urandom();
    endfunction

    // Loads a run of keys, sorted with duplicates most of the time.
    task automatic load_run(output int unsigned base, output int unsigned len);
        int unsigned pick;
        int unsigned step_cap;
        longint      level;
        bit          ordered;
        bit          top_max;
        pick = $urandom_range(0, 99);
        if (pick < 65)
            len = $urandom_range(1, 48);
        else if (pick < 95)
            len = $urandom_range(49, 220);
        else
            len = $urandom_range(221, 500);
        if (len > ITEM_TARGET - items_sent)
            len = ITEM_TARGET - items_sent;
        pick = $urandom_range(0, 99);
        if (pick < 15)
            base = DEPTH - len;
        else if (pick < 22)
            base = 0;
        else
            base = $urandom_range(0, DEPTH - len);
        ordered = $urandom_range(0, 99) < 85;
        top_max = $urandom_range(0, 9) == 0;
        case ($urandom_range(0, 2))
            0: step_cap = 2;
            1: step_cap = 1000;
            default: step_cap = 1 << 24;
        endcase
        level = ($urandom_range(0, 5) == 0) ? longint'(KEY_MIN)
                                            : (longint'($signed($urandom())) >>> 1);
        for (int unsigned i = 0; i < len; i++) begin
            if (!ordered)
                push_write(base + i, $urandom());
            else if (top_max && i == len - 1)
                push_write(base + i, KEY_MAX);
            else
                push_write(base + i, KEY_W'(level));
            level += $urandom_range(0, step_cap);
            if (level > KEY_MAX)
                level = KEY_MAX;
        end
    endtask

    task automatic random_search(input int unsigned lo, input int unsigned hi);
        int unsigned pick;
        int unsigned beg;
        int unsigned run;
        int unsigned stop;
        int unsigned rend;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            beg = $urandom_range(0, DEPTH - 1);
            push_search(beg, $urandom_range(0, beg), $urandom());
        end else begin
            beg = $urandom_range(lo, hi - 1);
            if (pick < 30) begin
                beg = $urandom_range(0, DEPTH - 1);
                if (!written[beg])
                    beg = $urandom_range(lo, hi - 1);
            end
            run = 0;
            while (beg + run < DEPTH && written[beg + run] && (pick < 30 || beg + run < hi))
                run++;
            stop = $urandom_range(0, 1) ? beg + run : beg + $urandom_range(1, run);
            rend = stop;
            if (stop == DEPTH && $urandom_range(0, 2) == 0)
                rend = $urandom_range(DEPTH, 8191);
            push_search(beg, rend, choose_key(beg, stop));
        end
    endtask

    initial begin
        int unsigned base;
        int unsigned len;
        int unsigned episode;
        rst_n             = 1'b0;
        in_valid          = 1'b0;
        op                = OP_WRITE;
        write_index       = '0;
        element_value     = '0;
        range_begin       = '0;
        range_end         = '0;
        search_key        = '0;
        items_sent        = 0;
        send_idle_pct     = 20;
        ready_idle_pct    = 20;
        calm              = 1'b0;
        long_hold_request = 1'b0;
        episode           = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        seed_keys = '{KEY_MIN, KEY_MIN, -5, -1, 0, 0, 1, 7, 100, 100, 100, 65535,
                      1000000, 32'sh7fff_fffe, KEY_MAX, KEY_MAX};
        for (int unsigned i = 0; i < 16; i++)
            push_write(4080 + i, seed_keys[i]);
        push_search(4080, 4096, KEY_MIN);
        push_search(4080, 4096, KEY_MAX);
        push_search(4080, 4090, KEY_MAX);
        push_search(4095, 8191, 0);
        push_search(4081, 4096, 100);
        push_search(4095, 100, 0);
        push_search(0, 0, 0);
        push_search(4090, 4090, -1);
        push_search(4082, 5000, 1);

        while (items_sent < ITEM_TARGET) begin
            episode++;
            calm = items_sent >= CALM_FROM;
            case ($urandom_range(0, 2))
                0: send_idle_pct = 0;
                1: send_idle_pct = 10;
                default: send_idle_pct = 40;
            endcase
            case ($urandom_range(0, 2))
                0: ready_idle_pct = 0;
                1: ready_idle_pct = 10;
                default: ready_idle_pct = 40;
            endcase
            load_run(base, len);
            if (episode == 3)
                long_hold_request = 1'b1;
            repeat ($urandom_range(4, 14)) begin
                if ($urandom_range(0, 99) < 4)
                    push_write($urandom_range(0, DEPTH - 1), $urandom());
                random_search(base, base + len);
            end
        end
        in_valid <= 1'b0;

        while (results_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
